// File: hw/rtl/vml_pkg.sv
`timescale 1ns / 1ps
package vml_pkg;

  localparam int CompWidthDef = 32;
  localparam int FracBitsDef  = 16;
  localparam int CfgWidth     = 32;

  localparam logic [CfgWidth-1:0]   MaxMagReset = {CfgWidth{1'b1}};
  localparam logic [2*CfgWidth-1:0] MaxSqReset  = MaxMagReset * MaxMagReset;

endpackage

// File: hw/rtl/vml_stream_if.sv
`timescale 1ns / 1ps
interface vml_in_if #(parameter int W = 32) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] comp_x;
  logic [W-1:0] comp_y;
  logic [W-1:0] comp_z;
  logic         pass_through;

  modport source (output valid, comp_x, comp_y, comp_z, pass_through, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, pass_through, output ready);
endinterface

interface vml_out_if #(parameter int W = 32) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] out_x;
  logic [W-1:0] out_y;
  logic [W-1:0] out_z;
  logic         was_limited;

  modport source (output valid, out_x, out_y, out_z, was_limited, input ready);
  modport sink   (input valid, out_x, out_y, out_z, was_limited, output ready);
endinterface

// File: hw/rtl/vml_front.sv
`timescale 1ns / 1ps
module vml_front import vml_pkg::*; #(
  parameter int W  = CompWidthDef,
  parameter int DW = 2 * CompWidthDef,
  parameter int IW = 3 * CompWidthDef + 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_vld,
  output logic                  up_rdy,
  input  logic [W-1:0]          comp_x,
  input  logic [W-1:0]          comp_y,
  input  logic [W-1:0]          comp_z,
  input  logic                  pass_through,
  input  logic [2*CfgWidth-1:0] max_sq,
  output logic                  dn_vld,
  input  logic                  dn_rdy,
  output logic [IW-1:0]         dn_item,
  output logic [DW-1:0]         dn_rem,
  output logic [DW-1:0]         dn_den
);

  logic [W-1:0]   mag_x, mag_y, mag_z;
  logic [2:0]     neg;
  logic           a_vld;
  logic           a_rdy;
  logic [W-1:0]   a_mag_x, a_mag_y, a_mag_z;
  logic [2:0]     a_neg;
  logic           a_pass;
  logic [2*W-1:0] a_sq_x, a_sq_y, a_sq_z;
  logic [DW-1:0]  v2;
  logic [DW-1:0]  m2;
  logic           lim;

  assign neg   = {comp_z[W-1], comp_y[W-1], comp_x[W-1]};
  assign mag_x = neg[0] ? (~comp_x + W'(1)) : comp_x;
  assign mag_y = neg[1] ? (~comp_y + W'(1)) : comp_y;
  assign mag_z = neg[2] ? (~comp_z + W'(1)) : comp_z;

  assign a_rdy  = !dn_vld || dn_rdy;
  assign up_rdy = !a_vld || a_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (up_rdy) begin
      a_vld <= up_vld;
    end
    if (up_rdy && up_vld) begin
      a_mag_x <= mag_x;
      a_mag_y <= mag_y;
      a_mag_z <= mag_z;
      a_neg   <= neg;
      a_pass  <= pass_through;
      a_sq_x  <= mag_x * mag_x;
      a_sq_y  <= mag_y * mag_y;
      a_sq_z  <= mag_z * mag_z;
    end
  end

  assign v2  = DW'(a_sq_x) + DW'(a_sq_y) + DW'(a_sq_z);
  assign m2  = DW'(max_sq);
  assign lim = !a_pass && (v2 > m2);

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_vld <= 1'b0;
    end else if (a_rdy) begin
      dn_vld <= a_vld;
    end
    if (a_rdy && a_vld) begin
      dn_item <= {lim, a_neg, a_mag_z, a_mag_y, a_mag_x};
      dn_rem  <= m2;
      dn_den  <= v2;
    end
  end

endmodule

// File: hw/rtl/vml_div_cell.sv
`timescale 1ns / 1ps
module vml_div_cell import vml_pkg::*; #(
  parameter int IW = 3 * CompWidthDef + 4,
  parameter int DW = 2 * CompWidthDef,
  parameter int QW = 2 * FracBitsDef
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_vld,
  output logic          up_rdy,
  input  logic [IW-1:0] up_item,
  input  logic [DW-1:0] up_rem,
  input  logic [DW-1:0] up_den,
  input  logic [QW-1:0] up_q,
  output logic          dn_vld,
  input  logic          dn_rdy,
  output logic [IW-1:0] dn_item,
  output logic [DW-1:0] dn_rem,
  output logic [DW-1:0] dn_den,
  output logic [QW-1:0] dn_q
);

  logic [DW:0] shl;
  logic [DW:0] diff;
  logic        ge;

  assign shl    = {up_rem, 1'b0};
  assign diff   = shl - {1'b0, up_den};
  assign ge     = shl >= {1'b0, up_den};
  assign up_rdy = !dn_vld || dn_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_vld <= 1'b0;
    end else if (up_rdy) begin
      dn_vld <= up_vld;
    end
    if (up_rdy && up_vld) begin
      dn_item <= up_item;
      dn_den  <= up_den;
      dn_rem  <= ge ? diff[DW-1:0] : shl[DW-1:0];
      dn_q    <= QW'({up_q, ge});
    end
  end

endmodule

// File: hw/rtl/vml_sqrt_cell.sv
`timescale 1ns / 1ps
module vml_sqrt_cell import vml_pkg::*; #(
  parameter int IW = 3 * CompWidthDef + 4,
  parameter int QW = 2 * FracBitsDef,
  parameter int SW = FracBitsDef
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_vld,
  output logic          up_rdy,
  input  logic [IW-1:0] up_item,
  input  logic [QW-1:0] up_q,
  input  logic [SW+1:0] up_rem,
  input  logic [SW-1:0] up_root,
  output logic          dn_vld,
  input  logic          dn_rdy,
  output logic [IW-1:0] dn_item,
  output logic [QW-1:0] dn_q,
  output logic [SW+1:0] dn_rem,
  output logic [SW-1:0] dn_root
);

  logic [SW+3:0] cur;
  logic [SW+3:0] trial;
  logic [SW+3:0] diff;
  logic          ge;

  assign cur    = {up_rem, up_q[QW-1:QW-2]};
  assign trial  = (SW+4)'({up_root, 2'b01});
  assign diff   = cur - trial;
  assign ge     = cur >= trial;
  assign up_rdy = !dn_vld || dn_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_vld <= 1'b0;
    end else if (up_rdy) begin
      dn_vld <= up_vld;
    end
    if (up_rdy && up_vld) begin
      dn_item <= up_item;
      dn_q    <= QW'({up_q, 2'b00});
      dn_rem  <= ge ? diff[SW+1:0] : cur[SW+1:0];
      dn_root <= SW'({up_root, ge});
    end
  end

endmodule

// File: hw/rtl/vml_scale_out.sv
`timescale 1ns / 1ps
module vml_scale_out import vml_pkg::*; #(
  parameter int W  = CompWidthDef,
  parameter int F  = FracBitsDef,
  parameter int SW = FracBitsDef,
  parameter int IW = 3 * CompWidthDef + 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_vld,
  output logic          up_rdy,
  input  logic [IW-1:0] up_item,
  input  logic [SW-1:0] up_root,
  vml_out_if.source     out_ch
);

  logic [W-1:0]    mag [3];
  logic [2:0]      neg;
  logic            lim;
  logic [SW-1:0]   s;
  logic [W+SW-1:0] prod [3];
  logic [W-1:0]    res  [3];

  assign neg = up_item[3*W +: 3];
  assign lim = up_item[3*W+3];
  assign s   = (F == 0) ? '0 : up_root;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]  = up_item[k*W +: W];
      prod[k] = (W+SW)'(mag[k]) * (W+SW)'(s);
      res[k]  = lim ? W'(prod[k] >> F) : mag[k];
      if (neg[k]) begin
        res[k] = ~res[k] + W'(1);
      end
    end
  end

  assign up_rdy = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (up_rdy) begin
      out_ch.valid <= up_vld;
    end
    if (up_rdy && up_vld) begin
      out_ch.out_x       <= res[0];
      out_ch.out_y       <= res[1];
      out_ch.out_z       <= res[2];
      out_ch.was_limited <= lim;
    end
  end

endmodule

// File: hw/rtl/vector_magnitude_limiter_core.sv
`timescale 1ns / 1ps
// channel   dir  handshake     payload
// in_ch     in   valid/ready   comp_x, comp_y, comp_z, pass_through
// out_ch    out  valid/ready   out_x, out_y, out_z, was_limited
// cfg       in   cfg_we        cfg_wdata -> max_magnitude
//
// One beat per cycle sustained while out_ch is not stalled; the chain is two front cells,
// one divider cell per quotient bit, one square-root cell per result bit and one
// output cell.
// Every cell holds its beat while the next cell is full and stalled; bubbles close up.
// Synchronous reset empties the chain and sets max_magnitude to all ones.
module vector_magnitude_limiter_core import vml_pkg::*; #(
  parameter int COMP_WIDTH = CompWidthDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  logic                clk,
  input  logic                rst,
  vml_in_if.sink              in_ch,
  vml_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [CfgWidth-1:0] cfg_wdata
);

  localparam int SW = (FRAC_BITS > 0) ? FRAC_BITS : 1;
  localparam int QW = 2 * SW;
  localparam int DW = (COMP_WIDTH > CfgWidth) ? 2 * COMP_WIDTH : 2 * CfgWidth;
  localparam int IW = 3 * COMP_WIDTH + 4;

  logic [CfgWidth-1:0]   max_mag;
  logic [2*CfgWidth-1:0] max_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_mag <= MaxMagReset;
      max_sq  <= MaxSqReset;
    end else begin
      if (cfg_we) begin
        max_mag <= cfg_wdata;
      end
      max_sq <= max_mag * max_mag;
    end
  end

  logic          d_vld  [QW+1];
  logic          d_rdy  [QW+1];
  logic [IW-1:0] d_item [QW+1];
  logic [DW-1:0] d_rem  [QW+1];
  logic [DW-1:0] d_den  [QW+1];
  logic [QW-1:0] d_q    [QW+1];

  logic          s_vld  [SW+1];
  logic          s_rdy  [SW+1];
  logic [IW-1:0] s_item [SW+1];
  logic [QW-1:0] s_q    [SW+1];
  logic [SW+1:0] s_rem  [SW+1];
  logic [SW-1:0] s_root [SW+1];

  vml_front #(.W(COMP_WIDTH), .DW(DW), .IW(IW)) u_front (
    .clk          (clk),
    .rst          (rst),
    .up_vld       (in_ch.valid),
    .up_rdy       (in_ch.ready),
    .comp_x       (in_ch.comp_x),
    .comp_y       (in_ch.comp_y),
    .comp_z       (in_ch.comp_z),
    .pass_through (in_ch.pass_through),
    .max_sq       (max_sq),
    .dn_vld       (d_vld[0]),
    .dn_rdy       (d_rdy[0]),
    .dn_item      (d_item[0]),
    .dn_rem       (d_rem[0]),
    .dn_den       (d_den[0])
  );

  assign d_q[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    vml_div_cell #(.IW(IW), .DW(DW), .QW(QW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_vld  (d_vld[i]),
      .up_rdy  (d_rdy[i]),
      .up_item (d_item[i]),
      .up_rem  (d_rem[i]),
      .up_den  (d_den[i]),
      .up_q    (d_q[i]),
      .dn_vld  (d_vld[i+1]),
      .dn_rdy  (d_rdy[i+1]),
      .dn_item (d_item[i+1]),
      .dn_rem  (d_rem[i+1]),
      .dn_den  (d_den[i+1]),
      .dn_q    (d_q[i+1])
    );
  end

  assign s_vld[0]  = d_vld[QW];
  assign d_rdy[QW] = s_rdy[0];
  assign s_item[0] = d_item[QW];
  assign s_q[0]    = d_q[QW];
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;

  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    vml_sqrt_cell #(.IW(IW), .QW(QW), .SW(SW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_vld  (s_vld[j]),
      .up_rdy  (s_rdy[j]),
      .up_item (s_item[j]),
      .up_q    (s_q[j]),
      .up_rem  (s_rem[j]),
      .up_root (s_root[j]),
      .dn_vld  (s_vld[j+1]),
      .dn_rdy  (s_rdy[j+1]),
      .dn_item (s_item[j+1]),
      .dn_q    (s_q[j+1]),
      .dn_rem  (s_rem[j+1]),
      .dn_root (s_root[j+1])
    );
  end

  vml_scale_out #(.W(COMP_WIDTH), .F(FRAC_BITS), .SW(SW), .IW(IW)) u_out (
    .clk     (clk),
    .rst     (rst),
    .up_vld  (s_vld[SW]),
    .up_rdy  (s_rdy[SW]),
    .up_item (s_item[SW]),
    .up_root (s_root[SW]),
    .out_ch  (out_ch)
  );

endmodule

// File: hw/rtl/vml_checker.sv
`timescale 1ns / 1ps
module vml_checker import vml_pkg::*; #(
  parameter int W = CompWidthDef
) (
  input logic         clk,
  input logic         rst,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] out_x,
  input logic [W-1:0] out_y,
  input logic [W-1:0] out_z,
  input logic         was_limited
);

  localparam logic [W-1:0] MostNeg = {1'b1, {(W-1){1'b0}}};

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(was_limited))
    else $error("stalled output beat changed");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_limited_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_limited |-> out_x != MostNeg && out_y != MostNeg && out_z != MostNeg)
    else $error("scaled component out of range");

endmodule

bind vector_magnitude_limiter_core vml_checker #(.W(COMP_WIDTH)) u_vml_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_x       (out_ch.out_x),
  .out_y       (out_ch.out_y),
  .out_z       (out_ch.out_z),
  .was_limited (out_ch.was_limited)
);
